>>> rtl/pld_pkg.sv
// Shared types and constants for the point to line distance pipeline.
// No dependencies; every rtl file refers to this package by scoped names.
`timescale 1ns / 1ps

package pld_pkg;

   localparam int FRAC_BITS_DEF = 16;

   // Foot numerators stay below 2^95 in magnitude; quotients need 33 bits
   // before the clamp, so the divider remainder is 64 + 33 bits wide.
   localparam int NUMW      = 96;
   localparam int QBITS     = 33;
   localparam int REMW      = 97;
   localparam int ROOT_BITS = 32;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_DEGEN = 2'd1,
      ST_SAT   = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [31:0] line_a;
      logic signed [31:0] line_b;
      logic signed [31:0] line_c;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic               want_foot;
   } req_type;

   typedef struct packed {
      logic        [31:0] distance;
      logic signed [31:0] foot_x;
      logic signed [31:0] foot_y;
      status_type         status;
   } rsp_type;

   // front end to divider
   typedef struct packed {
      logic               foot;
      logic               degen;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic [63:0]        den;
      logic [127:0]       sq;
      logic               nx_neg;
      logic [NUMW-1:0]    nx_mag;
      logic               ny_neg;
      logic [NUMW-1:0]    ny_mag;
   } front_type;

   // divider to root stage
   typedef struct packed {
      logic               foot;
      logic               degen;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic [63:0]        den;
      logic [127:0]       sq;
      logic signed [31:0] fx;
      logic signed [31:0] fy;
      logic               dsat;
   } div_out_type;

endpackage

>>> rtl/pld_front.sv
// Front end: products, line sums, foot numerators and their magnitudes.
// Six register stages; uses pld_pkg.
`timescale 1ns / 1ps

module pld_front #(
   parameter int FRAC_BITS = pld_pkg::FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  pld_pkg::req_type    in_data,
   output logic                out_valid,
   output pld_pkg::front_type  out_data
);

   localparam int NSTG = 6;

   typedef struct packed {
      logic               foot;
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [63:0] cs;
      logic signed [63:0] ax;
      logic signed [63:0] by;
      logic signed [63:0] bx;
      logic signed [63:0] ay;
      logic signed [63:0] aa;
      logic signed [63:0] bb;
   } s2_type;

   typedef struct packed {
      logic               foot;
      logic               degen;
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [63:0] cs;
      logic [63:0]        den;
      logic signed [64:0] dv;
      logic signed [65:0] nd;
   } s3_type;

   typedef struct packed {
      logic               foot;
      logic               degen;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic [63:0]        den;
      logic signed [64:0] bdh;
      logic signed [64:0] bdl;
      logic signed [64:0] adh;
      logic signed [64:0] adl;
      logic signed [64:0] ach;
      logic signed [64:0] acl;
      logic signed [64:0] bch;
      logic signed [64:0] bcl;
      logic signed [67:0] nhh;
      logic signed [66:0] nhl;
      logic [63:0]        nll;
   } s4_type;

   typedef struct packed {
      logic               foot;
      logic               degen;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic [63:0]        den;
      logic signed [97:0] nx;
      logic signed [97:0] ny;
      logic [127:0]       sq;
   } s5_type;

   logic [NSTG-1:0]    v_ff;
   pld_pkg::req_type   s1_ff;
   s2_type             s2_ff, s2_in;
   s3_type             s3_ff, s3_in;
   s4_type             s4_ff, s4_in;
   s5_type             s5_ff, s5_in;
   pld_pkg::front_type s6_ff, s6_in;

   logic signed [32:0]  dv_hi, dv_lo, cs_hi, cs_lo, nd_lo;
   logic signed [33:0]  nd_hi;
   logic signed [131:0] sq_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[NSTG-2:0], in_valid};
      end
   end

   always_comb begin
      s2_in.foot = s1_ff.want_foot;
      s2_in.a    = s1_ff.line_a;
      s2_in.b    = s1_ff.line_b;
      s2_in.px   = s1_ff.point_x;
      s2_in.py   = s1_ff.point_y;
      s2_in.cs   = 64'(s1_ff.line_c) <<< FRAC_BITS;
      s2_in.ax   = 64'(s1_ff.line_a) * 64'(s1_ff.point_x);
      s2_in.by   = 64'(s1_ff.line_b) * 64'(s1_ff.point_y);
      s2_in.bx   = 64'(s1_ff.line_b) * 64'(s1_ff.point_x);
      s2_in.ay   = 64'(s1_ff.line_a) * 64'(s1_ff.point_y);
      s2_in.aa   = 64'(s1_ff.line_a) * 64'(s1_ff.line_a);
      s2_in.bb   = 64'(s1_ff.line_b) * 64'(s1_ff.line_b);
   end

   always_comb begin
      s3_in.foot  = s2_ff.foot;
      s3_in.degen = (s2_ff.a == 32'sd0) && (s2_ff.b == 32'sd0);
      s3_in.a     = s2_ff.a;
      s3_in.b     = s2_ff.b;
      s3_in.px    = s2_ff.px;
      s3_in.py    = s2_ff.py;
      s3_in.cs    = s2_ff.cs;
      s3_in.den   = s2_ff.aa[63:0] + s2_ff.bb[63:0];
      s3_in.dv    = 65'(s2_ff.bx) - 65'(s2_ff.ay);
      s3_in.nd    = 66'(s2_ff.ax) + 66'(s2_ff.by) + 66'(s2_ff.cs);
   end

   // split the wide operands so every product is at most 34 by 34 bits
   always_comb begin
      dv_hi = $signed(s3_ff.dv[64:32]);
      dv_lo = $signed({1'b0, s3_ff.dv[31:0]});
      cs_hi = 33'($signed(s3_ff.cs[63:32]));
      cs_lo = $signed({1'b0, s3_ff.cs[31:0]});
      nd_hi = $signed(s3_ff.nd[65:32]);
      nd_lo = $signed({1'b0, s3_ff.nd[31:0]});

      s4_in.foot  = s3_ff.foot;
      s4_in.degen = s3_ff.degen;
      s4_in.px    = s3_ff.px;
      s4_in.py    = s3_ff.py;
      s4_in.den   = s3_ff.den;
      s4_in.bdh   = 65'(s3_ff.b) * 65'(dv_hi);
      s4_in.bdl   = 65'(s3_ff.b) * 65'(dv_lo);
      s4_in.adh   = 65'(s3_ff.a) * 65'(dv_hi);
      s4_in.adl   = 65'(s3_ff.a) * 65'(dv_lo);
      s4_in.ach   = 65'(s3_ff.a) * 65'(cs_hi);
      s4_in.acl   = 65'(s3_ff.a) * 65'(cs_lo);
      s4_in.bch   = 65'(s3_ff.b) * 65'(cs_hi);
      s4_in.bcl   = 65'(s3_ff.b) * 65'(cs_lo);
      s4_in.nhh   = 68'(nd_hi) * 68'(nd_hi);
      s4_in.nhl   = 67'(nd_hi) * 67'(nd_lo);
      s4_in.nll   = 64'(s3_ff.nd[31:0]) * 64'(s3_ff.nd[31:0]);
   end

   always_comb begin
      s5_in.foot  = s4_ff.foot;
      s5_in.degen = s4_ff.degen;
      s5_in.px    = s4_ff.px;
      s5_in.py    = s4_ff.py;
      s5_in.den   = s4_ff.den;
      s5_in.nx    = (98'(s4_ff.bdh) <<< 32) + 98'(s4_ff.bdl)
                  - (98'(s4_ff.ach) <<< 32) - 98'(s4_ff.acl);
      s5_in.ny    = 98'sd0 - (98'(s4_ff.adh) <<< 32) - 98'(s4_ff.adl)
                  - (98'(s4_ff.bch) <<< 32) - 98'(s4_ff.bcl);
      sq_full     = (132'(s4_ff.nhh) <<< 64) + (132'(s4_ff.nhl) <<< 33)
                  + 132'($signed({1'b0, s4_ff.nll}));
      s5_in.sq    = sq_full[127:0];
   end

   always_comb begin
      s6_in.foot   = s5_ff.foot;
      s6_in.degen  = s5_ff.degen;
      s6_in.px     = s5_ff.px;
      s6_in.py     = s5_ff.py;
      s6_in.den    = s5_ff.den;
      s6_in.sq     = s5_ff.sq;
      s6_in.nx_neg = s5_ff.nx[97];
      s6_in.ny_neg = s5_ff.ny[97];
      s6_in.nx_mag = s5_ff.nx[97] ? pld_pkg::NUMW'(-s5_ff.nx)
                                  : s5_ff.nx[pld_pkg::NUMW-1:0];
      s6_in.ny_mag = s5_ff.ny[97] ? pld_pkg::NUMW'(-s5_ff.ny)
                                  : s5_ff.ny[pld_pkg::NUMW-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff <= in_data;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
         s6_ff <= s6_in;
      end
   end

   assign out_valid = v_ff[NSTG-1];
   assign out_data  = s6_ff;

endmodule

>>> rtl/pld_div.sv
// Pipelined restoring divider, two lanes sharing one divisor, then clamp.
// One quotient bit per stage; uses pld_pkg.
`timescale 1ns / 1ps

module pld_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  pld_pkg::front_type   in_data,
   output logic                 out_valid,
   output pld_pkg::div_out_type out_data
);

   localparam int QB   = pld_pkg::QBITS;
   localparam int RW   = pld_pkg::REMW;
   localparam int NS   = QB + 1;

   typedef struct packed {
      pld_pkg::front_type f;
      logic [RW-1:0]      rx;
      logic [RW-1:0]      ry;
      logic [QB-1:0]      qx;
      logic [QB-1:0]      qy;
      logic               ox;
      logic               oy;
   } dstg_type;

   dstg_type             st_ff [NS];
   dstg_type             st_in [NS];
   logic [NS-1:0]        v_ff;
   pld_pkg::div_out_type o_ff, o_in;
   logic                 vo_ff;
   logic [RW-1:0]        lim;
   logic [32:0]          cx, cy;

   function automatic logic [32:0] clamp_q(input logic neg, input logic ovf,
                                           input logic [QB-1:0] q);
      logic [32:0] r;
      if (!neg) begin
         if (ovf || q > 33'h07FFFFFFF) r = {1'b1, 32'h7FFFFFFF};
         else r = {1'b0, q[31:0]};
      end else begin
         if (ovf || q > 33'h080000000) r = {1'b1, 32'h80000000};
         else r = {1'b0, 32'((~q[31:0]) + 32'd1)};
      end
      return r;
   endfunction

   always_comb begin
      logic [RW-1:0] trial;
      // quotient of 2^33 or more can only clamp; flag it up front
      lim            = {in_data.den, {QB{1'b0}}};
      st_in[0].f     = in_data;
      st_in[0].rx    = {1'b0, in_data.nx_mag};
      st_in[0].ry    = {1'b0, in_data.ny_mag};
      st_in[0].qx    = '0;
      st_in[0].qy    = '0;
      st_in[0].ox    = {1'b0, in_data.nx_mag} >= lim;
      st_in[0].oy    = {1'b0, in_data.ny_mag} >= lim;
      for (int k = 1; k < NS; k++) begin
         st_in[k] = st_ff[k-1];
         trial    = RW'(st_ff[k-1].f.den) << (QB - k);
         if (st_ff[k-1].rx >= trial) begin
            st_in[k].rx        = st_ff[k-1].rx - trial;
            st_in[k].qx[QB-k]  = 1'b1;
         end
         if (st_ff[k-1].ry >= trial) begin
            st_in[k].ry        = st_ff[k-1].ry - trial;
            st_in[k].qy[QB-k]  = 1'b1;
         end
      end
   end

   always_comb begin
      cx         = clamp_q(st_ff[NS-1].f.nx_neg, st_ff[NS-1].ox, st_ff[NS-1].qx);
      cy         = clamp_q(st_ff[NS-1].f.ny_neg, st_ff[NS-1].oy, st_ff[NS-1].qy);
      o_in.foot  = st_ff[NS-1].f.foot;
      o_in.degen = st_ff[NS-1].f.degen;
      o_in.px    = st_ff[NS-1].f.px;
      o_in.py    = st_ff[NS-1].f.py;
      o_in.den   = st_ff[NS-1].f.den;
      o_in.sq    = st_ff[NS-1].f.sq;
      o_in.fx    = $signed(cx[31:0]);
      o_in.fy    = $signed(cy[31:0]);
      o_in.dsat  = cx[32] | cy[32];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff  <= '0;
         vo_ff <= 1'b0;
      end else if (en) begin
         v_ff  <= {v_ff[NS-2:0], in_valid};
         vo_ff <= v_ff[NS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff <= st_in;
         o_ff  <= o_in;
      end
   end

   assign out_valid = vo_ff;
   assign out_data  = o_ff;

endmodule

>>> rtl/pld_root.sv
// Distance stage: foot offsets and squares, then a pipelined scaled root
// that finds the largest d with d*d*m <= t, one bit per stage; uses pld_pkg.
`timescale 1ns / 1ps

module pld_root (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  pld_pkg::div_out_type in_data,
   output logic                 out_valid,
   output pld_pkg::rsp_type     out_data
);

   localparam int RB = pld_pkg::ROOT_BITS;
   localparam int NV = RB + 4;

   typedef struct packed {
      logic               foot;
      logic               degen;
      logic signed [31:0] fx;
      logic signed [31:0] fy;
      logic               dsat;
      logic [63:0]        den;
      logic [127:0]       sq;
      logic signed [33:0] dx;
      logic signed [33:0] dy;
   } r0_type;

   typedef struct packed {
      logic               foot;
      logic               degen;
      logic signed [31:0] fx;
      logic signed [31:0] fy;
      logic               dsat;
      logic [63:0]        den;
      logic [127:0]       sq;
      logic [67:0]        dxx;
      logic [67:0]        dyy;
   } r1_type;

   typedef struct packed {
      logic               foot;
      logic               degen;
      logic signed [31:0] fx;
      logic signed [31:0] fy;
      logic               dsat;
      logic [63:0]        m;
      logic [127:0]       t;
   } r2_type;

   typedef struct packed {
      logic               foot;
      logic               degen;
      logic signed [31:0] fx;
      logic signed [31:0] fy;
      logic               dsat;
      logic               rsat;
      logic [63:0]        m;
      logic [129:0]       r;
      logic [96:0]        p;
      logic [RB-1:0]      d;
   } rs_type;

   logic [NV-1:0] v_ff;
   r0_type        r0_ff, r0_in;
   r1_type        r1_ff, r1_in;
   r2_type        r2_ff, r2_in;
   rs_type        rs_ff [RB+1];
   rs_type        rs_in [RB+1];
   rs_type        last;

   always_comb begin
      r0_in.foot  = in_data.foot;
      r0_in.degen = in_data.degen;
      r0_in.fx    = in_data.fx;
      r0_in.fy    = in_data.fy;
      r0_in.dsat  = in_data.dsat;
      r0_in.den   = in_data.den;
      r0_in.sq    = in_data.sq;
      r0_in.dx    = 34'(in_data.px) - 34'(in_data.fx);
      r0_in.dy    = 34'(in_data.py) - 34'(in_data.fy);
   end

   always_comb begin
      r1_in.foot  = r0_ff.foot;
      r1_in.degen = r0_ff.degen;
      r1_in.fx    = r0_ff.fx;
      r1_in.fy    = r0_ff.fy;
      r1_in.dsat  = r0_ff.dsat;
      r1_in.den   = r0_ff.den;
      r1_in.sq    = r0_ff.sq;
      r1_in.dxx   = 68'(r0_ff.dx) * 68'(r0_ff.dx);
      r1_in.dyy   = 68'(r0_ff.dy) * 68'(r0_ff.dy);
   end

   // foot mode takes the plain root of dx^2 + dy^2
   always_comb begin
      r2_in.foot  = r1_ff.foot;
      r2_in.degen = r1_ff.degen;
      r2_in.fx    = r1_ff.fx;
      r2_in.fy    = r1_ff.fy;
      r2_in.dsat  = r1_ff.dsat;
      r2_in.m     = r1_ff.foot ? 64'd1 : r1_ff.den;
      r2_in.t     = r1_ff.foot ? (128'(r1_ff.dxx) + 128'(r1_ff.dyy)) : r1_ff.sq;
   end

   always_comb begin
      logic [129:0] trial;
      rs_in[0].foot  = r2_ff.foot;
      rs_in[0].degen = r2_ff.degen;
      rs_in[0].fx    = r2_ff.fx;
      rs_in[0].fy    = r2_ff.fy;
      rs_in[0].dsat  = r2_ff.dsat;
      rs_in[0].rsat  = {r2_ff.m, 64'd0} <= r2_ff.t;
      rs_in[0].m     = r2_ff.m;
      rs_in[0].r     = 130'(r2_ff.t);
      rs_in[0].p     = '0;
      rs_in[0].d     = '0;
      // r holds t - d*d*m and p holds d*m, so each trial is adds and shifts
      for (int k = 1; k <= RB; k++) begin
         rs_in[k] = rs_ff[k-1];
         trial    = (130'(rs_ff[k-1].p) << (RB - k + 1))
                  + (130'(rs_ff[k-1].m) << (2 * (RB - k)));
         if (trial <= rs_ff[k-1].r) begin
            rs_in[k].r       = rs_ff[k-1].r - trial;
            rs_in[k].p       = rs_ff[k-1].p + (97'(rs_ff[k-1].m) << (RB - k));
            rs_in[k].d[RB-k] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[NV-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r0_ff <= r0_in;
         r1_ff <= r1_in;
         r2_ff <= r2_in;
         rs_ff <= rs_in;
      end
   end

   assign last = rs_ff[RB];

   always_comb begin
      if (last.degen) begin
         out_data.distance = '0;
         out_data.foot_x   = '0;
         out_data.foot_y   = '0;
         out_data.status   = pld_pkg::ST_DEGEN;
      end else begin
         out_data.distance = last.rsat ? 32'hFFFFFFFF : last.d;
         out_data.foot_x   = last.foot ? last.fx : 32'sd0;
         out_data.foot_y   = last.foot ? last.fy : 32'sd0;
         out_data.status   = (last.rsat || (last.foot && last.dsat)) ? pld_pkg::ST_SAT
                                                                      : pld_pkg::ST_OK;
      end
   end

   assign out_valid = v_ff[NV-1];

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid && last.degen |-> out_data.distance == 32'd0 &&
      out_data.status == pld_pkg::ST_DEGEN)
      else $error("degenerate line result not cleared");

   a_no_foot_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid && !last.foot && !last.degen |->
      out_data.foot_x == 32'sd0 && out_data.foot_y == 32'sd0)
      else $error("foot reported without request");

   a_root_sat: assert property (@(posedge clock) disable iff (reset)
      out_valid && last.rsat && !last.degen |->
      out_data.distance == 32'hFFFFFFFF && out_data.status == pld_pkg::ST_SAT)
      else $error("saturated distance not clamped");

endmodule

>>> rtl/pld_skid.sv
// Output register with a one entry skid buffer for the result channel.
// Uses pld_pkg for the result type.
`timescale 1ns / 1ps

module pld_skid (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  pld_pkg::rsp_type in_data,
   output logic             in_stall,
   output logic             out_valid,
   output pld_pkg::rsp_type out_data,
   input  logic             out_stall
);

   logic             out_v_ff, skid_v_ff;
   pld_pkg::rsp_type out_ff, skid_ff;
   logic             out_take;

   assign out_take = out_v_ff & ~out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (out_take) begin
            skid_v_ff <= 1'b0;
         end
      end else if (in_valid) begin
         if (!out_v_ff || out_take) begin
            out_v_ff <= 1'b1;
         end else begin
            skid_v_ff <= 1'b1;
         end
      end else if (out_take) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (out_take) out_ff <= skid_ff;
      end else if (in_valid) begin
         if (!out_v_ff || out_take) out_ff <= in_data;
         else skid_ff <= in_data;
      end
   end

   assign in_stall  = skid_v_ff;
   assign out_valid = out_v_ff;
   assign out_data  = out_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid entry without output entry");

   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff && !out_stall |=> !skid_v_ff)
      else $error("skid entry not drained");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      in_valid && !skid_v_ff && out_v_ff && out_stall |=> skid_v_ff)
      else $error("blocked transfer not captured");

endmodule

>>> rtl/point_line_distance_foot_top.sv
// Point to line distance with optional perpendicular foot, Q16.16 style.
// Instantiates pld_front, pld_div, pld_root and pld_skid; uses pld_pkg.
//
// Usage:
//   req_* carries one line a*x+b*y+c=0 and one point per transfer, with
//   want_foot selecting foot plus distance to the foot, or plain distance.
//   rsp_* returns one result per request, in request order: distance,
//   foot coordinates (zero unless requested) and status.
//   A transfer happens on a clock edge with valid high and stall low.
// Throughput: one request per cycle while req_stall is low.
// Pipeline: front end products and sums, then the quotient pipeline and
//   the root pipeline; the result leaves through the skid output register.
// Reset: synchronous; clears all valid bits, the pipeline is empty after.
// Stall: rsp_stall freezes nothing at first; a result that meets a stall
//   goes to a one entry skid buffer, and while that entry is full the whole
//   pipeline holds and req_stall is high. Nothing is dropped or repeated.
`timescale 1ns / 1ps

module point_line_distance_foot_top #(
   parameter int FRAC_BITS = pld_pkg::FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pld_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pld_pkg::rsp_type rsp_data
);

   logic                 en;
   logic                 skid_stall;
   logic                 front_valid, div_valid, root_valid;
   pld_pkg::front_type   front_data;
   pld_pkg::div_out_type div_data;
   pld_pkg::rsp_type     root_data;

   // advance every stage whenever the skid entry is free
   assign en        = ~skid_stall;
   assign req_stall = skid_stall;

   pld_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   pld_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .out_valid (div_valid),
      .out_data  (div_data)
   );

   pld_root u_root (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (div_valid),
      .in_data   (div_data),
      .out_valid (root_valid),
      .out_data  (root_data)
   );

   pld_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (root_valid),
      .in_data   (root_data),
      .in_stall  (skid_stall),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .out_stall (rsp_stall)
   );

endmodule
